// File: hw/rtl/wav_data_chunk_extractor_macros.svh
// ----------------------------------------------------------------------------
// WAV data chunk extractor: assertion macros
// Shorthand for the clocked, reset-qualified checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef WAV_DATA_CHUNK_EXTRACTOR_MACROS_SVH
`define WAV_DATA_CHUNK_EXTRACTOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define WDCE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wdce check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define WDCE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wdce check failed");

`endif

// File: hw/rtl/wdce_pkg.sv
// ----------------------------------------------------------------------------
// WAV data chunk extractor package
// Transfer types, parser phases, status codes and the RIFF/WAVE tags.
// ----------------------------------------------------------------------------
`default_nettype none

package wdce_pkg;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_CHUNK  = 3'd1,
    PH_SKIP   = 3'd2,
    PH_DATA   = 3'd3,
    PH_IDLE   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_SAMPLE    = 2'd0,
    ST_DATA_HDR  = 2'd1,
    ST_BAD_MAGIC = 2'd2,
    ST_NO_DATA   = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
    logic       file_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic signed [15:0]  sample;
    logic [31:0]         chunk_size;
    logic                last_sample;
  } out_item_t;

  // Tags indexed by byte position, entry 0 is the first byte in the stream
  localparam logic [3:0][7:0] RiffTag = {8'h46, 8'h46, 8'h49, 8'h52};
  localparam logic [3:0][7:0] WaveTag = {8'h45, 8'h56, 8'h41, 8'h57};
  localparam logic [3:0][7:0] DataTag = {8'h61, 8'h74, 8'h61, 8'h64};

  localparam logic [3:0] FileHdrLast  = 4'd11;
  localparam logic [3:0] WaveTagFirst = 4'd8;
  localparam logic [3:0] RiffTagEnd   = 4'd4;
  localparam logic [2:0] ChunkHdrLast = 3'd7;

endpackage

`default_nettype wire

// File: hw/rtl/wav_data_chunk_extractor.sv
// ----------------------------------------------------------------------------
// WAV data chunk extractor
// Parses a RIFF/WAVE byte stream, reports the data chunk size and packs the
// data bytes into little-endian 16-bit samples.
// ----------------------------------------------------------------------------
// An input transfer passes through the input register, then through the parser
//   logic into the result register.
// Throughput: one byte per cycle unless the output stalls; the parser state
// is one register stage. Bytes that give no result put no item on the output.
// Reset: asynchronous, active low; parser expects a file header, no items held.
`default_nettype none

`include "wav_data_chunk_extractor_macros.svh"

module wav_data_chunk_extractor (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wdce_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output wdce_pkg::out_item_t out_data_o
);

  // input register
  logic               in_vld_q, in_vld_d;
  wdce_pkg::in_item_t in_q;

  // result register
  logic                out_vld_q, out_vld_d;
  wdce_pkg::out_item_t out_q;

  // parser state
  wdce_pkg::phase_e phase_q, phase_d, phase_c;
  logic [3:0]       hcnt_q, hcnt_d, hcnt_c;
  logic             magic_q, magic_d, magic_c;
  logic             isdata_q, isdata_d, isdata_c;
  logic [3:0][7:0]  size_q, size_d, size_c;
  logic [32:0]      left_q, left_d, left_c, left_dec;
  logic [7:0]       low_q, low_d, low_c;
  logic             have_q, have_d, have_c;

  logic                fire;
  logic                accept;
  logic                res_vld;
  wdce_pkg::out_item_t res;

  assign fire       = in_vld_q && !(out_vld_q && out_stall_i);
  assign in_stall_o = in_vld_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (!out_vld_q || !out_stall_i) begin
      out_vld_d = fire && res_vld;
    end
  end

  always_comb begin
    // a file start restarts parsing on this very byte
    phase_c  = phase_q;
    hcnt_c   = hcnt_q;
    magic_c  = magic_q;
    isdata_c = isdata_q;
    size_c   = size_q;
    left_c   = left_q;
    low_c    = low_q;
    have_c   = have_q;
    if (in_q.file_start) begin
      phase_c  = wdce_pkg::PH_HEADER;
      hcnt_c   = '0;
      magic_c  = 1'b1;
      isdata_c = 1'b1;
      size_c   = '0;
      left_c   = '0;
      low_c    = '0;
      have_c   = 1'b0;
    end

    phase_d  = phase_c;
    hcnt_d   = hcnt_c;
    magic_d  = magic_c;
    isdata_d = isdata_c;
    size_d   = size_c;
    left_d   = left_c;
    low_d    = low_c;
    have_d   = have_c;
    res_vld  = 1'b0;
    res      = '0;
    left_dec = left_c - 33'd1;

    case (phase_c)
      wdce_pkg::PH_HEADER: begin
        if (hcnt_c < wdce_pkg::RiffTagEnd &&
            in_q.data_byte != wdce_pkg::RiffTag[hcnt_c[1:0]]) begin
          magic_d = 1'b0;
        end
        if (hcnt_c >= wdce_pkg::WaveTagFirst && hcnt_c <= wdce_pkg::FileHdrLast &&
            in_q.data_byte != wdce_pkg::WaveTag[hcnt_c[1:0]]) begin
          magic_d = 1'b0;
        end
        if (hcnt_c >= wdce_pkg::FileHdrLast) begin
          if (!magic_d) begin
            res_vld    = 1'b1;
            res.status = wdce_pkg::ST_BAD_MAGIC;
            phase_d    = wdce_pkg::PH_IDLE;
          end else begin
            phase_d  = wdce_pkg::PH_CHUNK;
            hcnt_d   = '0;
            isdata_d = 1'b1;
            size_d   = '0;
          end
        end else begin
          hcnt_d = hcnt_c + 4'd1;
        end
      end
      wdce_pkg::PH_CHUNK: begin
        if (!hcnt_c[2]) begin
          if (in_q.data_byte != wdce_pkg::DataTag[hcnt_c[1:0]]) begin
            isdata_d = 1'b0;
          end
        end else begin
          size_d[hcnt_c[1:0]] = size_c[hcnt_c[1:0]] | in_q.data_byte;
        end
        if (hcnt_c[2:0] == wdce_pkg::ChunkHdrLast) begin
          if (isdata_d) begin
            res_vld        = 1'b1;
            res.status     = wdce_pkg::ST_DATA_HDR;
            res.chunk_size = size_d;
            left_d         = {1'b0, size_d};
            have_d         = 1'b0;
            phase_d        = (size_d == '0) ? wdce_pkg::PH_IDLE : wdce_pkg::PH_DATA;
          end else begin
            // skip length padded to even, 33 bits so an all-ones size does not wrap
            left_d = {1'b0, size_d} + {32'd0, size_d[0][0]};
            if (left_d == '0) begin
              phase_d  = wdce_pkg::PH_CHUNK;
              hcnt_d   = '0;
              isdata_d = 1'b1;
              size_d   = '0;
            end else begin
              phase_d = wdce_pkg::PH_SKIP;
            end
          end
        end else begin
          hcnt_d = {1'b0, hcnt_c[2:0] + 3'd1};
        end
      end
      wdce_pkg::PH_SKIP: begin
        left_d = left_dec;
        if (left_dec == '0) begin
          phase_d  = wdce_pkg::PH_CHUNK;
          hcnt_d   = '0;
          isdata_d = 1'b1;
          size_d   = '0;
        end
      end
      wdce_pkg::PH_DATA: begin
        left_d = left_dec;
        if (have_c) begin
          res_vld         = 1'b1;
          res.status      = wdce_pkg::ST_SAMPLE;
          res.sample      = signed'({in_q.data_byte, low_c});
          res.last_sample = (left_dec < 33'd2) || in_q.file_end;
          have_d          = 1'b0;
        end else begin
          low_d  = in_q.data_byte;
          have_d = 1'b1;
        end
        if (left_dec == '0) begin
          phase_d = wdce_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_d = wdce_pkg::PH_IDLE;
      end
    endcase

    if (in_q.file_end) begin
      // file ended before the data chunk, unless bad magic was already flagged
      if (!res_vld && (phase_d == wdce_pkg::PH_HEADER || phase_d == wdce_pkg::PH_CHUNK ||
                       phase_d == wdce_pkg::PH_SKIP)) begin
        res_vld    = 1'b1;
        res.status = wdce_pkg::ST_NO_DATA;
      end
      phase_d = wdce_pkg::PH_IDLE;
      have_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= wdce_pkg::PH_HEADER;
      hcnt_q    <= '0;
      magic_q   <= 1'b1;
      isdata_q  <= 1'b1;
      size_q    <= '0;
      left_q    <= '0;
      low_q     <= '0;
      have_q    <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (fire) begin
        phase_q  <= phase_d;
        hcnt_q   <= hcnt_d;
        magic_q  <= magic_d;
        isdata_q <= isdata_d;
        size_q   <= size_d;
        left_q   <= left_d;
        low_q    <= low_d;
        have_q   <= have_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (fire && res_vld) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `WDCE_ASSERT_IMP(a_data_left_nonzero, phase_q == wdce_pkg::PH_DATA, left_q != '0)
  `WDCE_ASSERT_IMP(a_skip_left_nonzero, phase_q == wdce_pkg::PH_SKIP, left_q != '0)
  `WDCE_ASSERT_IMP(a_chunk_hdr_count, phase_q == wdce_pkg::PH_CHUNK, hcnt_q[3] == 1'b0)
  `WDCE_ASSERT_NXT(a_result_loaded, fire && res_vld, out_vld_q)

endmodule

`default_nettype wire
